### sv/xcfd_pkg.sv
package xcfd_pkg;

  localparam int MaxPayloadDefault = 12;

  localparam logic [7:0] Hdr0      = 8'hAA;
  localparam logic [7:0] Hdr1      = 8'h55;
  localparam logic [7:0] TypeBall  = 8'h01;
  localparam logic [7:0] TypeCtrl  = 8'h02;
  localparam logic [7:0] TypeTune  = 8'h04;
  localparam logic [7:0] TypeStart = 8'h05;
  localparam logic [7:0] ConfMax   = 8'd100;

  localparam logic [1:0] KindBall  = 2'd0;
  localparam logic [1:0] KindCtrl  = 2'd1;
  localparam logic [1:0] KindTune  = 2'd2;
  localparam logic [1:0] KindStart = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_TYPE, PH_LEN, PH_BODY, PH_CHECK
  } phase_t;

  // Frame handed from the parser to the decoder: a snapshot of the payload.
  typedef struct packed {
    logic [1:0]       kind;
    logic [3:0]       len;
    logic [12*8-1:0]  data;
  } frame_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [1:0]  slot;
    logic [15:0] signed_word;
    logic [15:0] unsigned_word;
    logic [15:0] ball_frame_time;
    logic [7:0]  small_a;
    logic [7:0]  small_b;
    logic [7:0]  small_c;
    logic [7:0]  slot_bias;
    logic [1:0]  meta_flags;
    logic [15:0] revision_count;
    logic        last_of_run;
  } result_t;

endpackage

### sv/xor_checked_frame_decoder_unit.sv
// Byte-stream deframer for AA 55 TYPE LEN PAYLOAD XOR frames. One byte beat is
// accepted every clock while in_stall is low: the parser itself never stalls the
// input. A checked frame whose type and length are recognised is passed through a
// two-entry frame queue to the decoder. The decoder emits one result beat per cycle
// whenever the output is not stalled: one for ball and control frames, three
// for tune, four for start. Between runs it emits nothing while it loads the
// next frame. The first beat of a frame passes the parser's frame register, the
// queue slot and the decoder's latched frame before the registered result. Input
// stalls whenever the queue holds two frames, counting one just leaving the
// parser; this applies to any byte, not only a check byte. Frames are at least
// eight bytes apart, so this needs a long output stall. Configuration (default
// biases) is written through a plain write port.
module xor_checked_frame_decoder_unit #(
  parameter int MAX_PAYLOAD = xcfd_pkg::MaxPayloadDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  frame_kind,
  output logic [1:0]  slot,
  output logic signed [15:0] signed_word,
  output logic [15:0] unsigned_word,
  output logic [15:0] ball_frame_time,
  output logic [7:0]  small_a,
  output logic [7:0]  small_b,
  output logic [7:0]  small_c,
  output logic signed [7:0] slot_bias,
  output logic [1:0]  meta_flags,
  output logic [15:0] revision_count,
  output logic        last_of_run
);
  import xcfd_pkg::*;

  logic [7:0] default_bias [4];
  logic       in_fire;
  logic       pfv;
  frame_t     pframe, qhead;
  logic       q_ne, q_pop;
  logic [1:0] q_cnt;
  result_t    res;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) default_bias[i] <= '0;
    end else if (cfg_we) begin
      default_bias[cfg_index] <= cfg_data;
    end
  end

  // Stall conservatively while the queue may fill: the parser's output is
  // registered in the cycle after the check byte, so count that pending frame too.
  always_ff @(posedge clk) begin
    if (rst) q_cnt <= '0;
    else q_cnt <= q_cnt + 2'(pfv) - 2'(q_pop);
  end
  assign in_stall = (q_cnt + 2'(pfv)) >= 2'd2;
  assign in_fire  = in_valid && !in_stall;

  xcfd_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parser (
    .clk, .rst, .in_fire, .rx_byte, .frame_valid(pfv), .frame(pframe)
  );

  xcfd_fifo u_fifo (
    .clk, .rst, .push(pfv), .push_data(pframe), .pop(q_pop),
    .not_empty(q_ne), .head(qhead)
  );

  xcfd_decoder u_dec (
    .clk, .rst, .default_bias, .frame_ready(q_ne), .frame(qhead), .frame_pop(q_pop),
    .res_valid(out_valid), .res, .res_stall(out_stall)
  );

  assign frame_kind      = res.frame_kind;
  assign slot            = res.slot;
  assign signed_word     = res.signed_word;
  assign unsigned_word   = res.unsigned_word;
  assign ball_frame_time = res.ball_frame_time;
  assign small_a         = res.small_a;
  assign small_b         = res.small_b;
  assign small_c         = res.small_c;
  assign slot_bias       = res.slot_bias;
  assign meta_flags      = res.meta_flags;
  assign revision_count  = res.revision_count;
  assign last_of_run     = res.last_of_run;

endmodule

### sv/xcfd_parser.sv
module xcfd_parser #(
  parameter int MAX_PAYLOAD = xcfd_pkg::MaxPayloadDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [7:0]        rx_byte,
  output logic              frame_valid,
  output xcfd_pkg::frame_t  frame
);
  import xcfd_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  held_type;
  logic [3:0]  held_length;
  logic [3:0]  payload_count;
  logic [7:0]  running_xor;
  logic [7:0]  payload [12];
  logic        accepted;
  logic [1:0]  kind;

  // Only lengths the decoder acts on are passed through; everything else is dropped here.
  always_comb begin
    accepted = 1'b0;
    kind     = KindBall;
    case (held_type)
      TypeBall: begin
        kind = KindBall;
        accepted = (held_length == 4'd3) || (held_length == 4'd7) || (held_length == 4'd8);
      end
      TypeCtrl: begin
        kind = KindCtrl;
        accepted = (held_length == 4'd5);
      end
      TypeTune: begin
        kind = KindTune;
        accepted = (held_length == 4'd12);
      end
      TypeStart: begin
        kind = KindStart;
        accepted = (held_length == 4'd6) || (held_length == 4'd10);
      end
      default: accepted = 1'b0;
    endcase
  end

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HDR0: if (rx_byte == Hdr0) phase_next = PH_HDR1;
      PH_HDR1: begin
        if (rx_byte == Hdr1) phase_next = PH_TYPE;
        else if (rx_byte == Hdr0) phase_next = PH_HDR1;
        else phase_next = PH_HDR0;
      end
      PH_TYPE: phase_next = PH_LEN;
      PH_LEN: begin
        if (rx_byte > 8'(MAX_PAYLOAD)) phase_next = PH_HDR0;
        else if (rx_byte == 8'd0) phase_next = PH_CHECK;
        else phase_next = PH_BODY;
      end
      PH_BODY: if ((payload_count + 4'd1) >= held_length) phase_next = PH_CHECK;
      PH_CHECK: phase_next = PH_HDR0;
      default: phase_next = PH_HDR0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      held_type     <= '0;
      held_length   <= '0;
      payload_count <= '0;
      running_xor   <= '0;
      frame_valid   <= 1'b0;
    end else begin
      frame_valid <= 1'b0;
      if (in_fire) begin
        phase <= phase_next;
        case (phase)
          PH_TYPE: begin
            held_type   <= rx_byte;
            running_xor <= rx_byte;
          end
          PH_LEN: begin
            if (rx_byte <= 8'(MAX_PAYLOAD)) begin
              held_length   <= rx_byte[3:0];
              payload_count <= '0;
              running_xor   <= running_xor ^ rx_byte;
            end
          end
          PH_BODY: begin
            if (payload_count < 4'd12) payload[payload_count] <= rx_byte;
            payload_count <= payload_count + 4'd1;
            running_xor   <= running_xor ^ rx_byte;
          end
          PH_CHECK: frame_valid <= (rx_byte == running_xor) && accepted;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && phase == PH_CHECK) begin
      frame.kind <= kind;
      frame.len  <= held_length;
      for (int i = 0; i < 12; i++) frame.data[i*8 +: 8] <= payload[i];
    end
  end

endmodule

### sv/xcfd_fifo.sv
module xcfd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xcfd_pkg::frame_t  push_data,
  input  logic              pop,
  output logic              not_empty,
  output xcfd_pkg::frame_t  head
);
  import xcfd_pkg::*;

  frame_t     slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assert property (@(posedge clk) disable iff (rst) !(pop && count == 2'd0))
    else $error("frame queue underflow");
  assert property (@(posedge clk) disable iff (rst) !(push && count == 2'd2 && !pop))
    else $error("frame queue overflow");

endmodule

### sv/xcfd_decoder.sv
module xcfd_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         default_bias [4],
  input  logic               frame_ready,
  input  xcfd_pkg::frame_t   frame,
  output logic               frame_pop,
  output logic               res_valid,
  output xcfd_pkg::result_t  res,
  input  logic               res_stall
);
  import xcfd_pkg::*;

  logic [15:0] tune_angles [3];
  logic [15:0] tune_times  [3];
  logic        tune_seen;
  logic [15:0] tune_revision;
  logic [15:0] start_angles [3];
  logic [7:0]  bias_store [4];
  logic        bias_loaded;
  logic        start_seen;
  logic [15:0] start_revision;

  logic        busy;      // run in progress, frame data latched
  logic [1:0]  idx;
  frame_t      cur;
  logic [7:0]  b [12];
  logic        changed;
  logic [7:0]  bias_now [4];
  logic [1:0]  last_idx;
  result_t     r;
  logic        emit;

  always_comb begin
    for (int i = 0; i < 12; i++) b[i] = frame.data[i*8 +: 8];
    for (int i = 0; i < 4; i++) bias_now[i] = bias_loaded ? bias_store[i] : default_bias[i];
  end

  // Change detection at frame load; updates stored state in the same cycle.
  always_comb begin
    changed = 1'b0;
    if (frame.kind == KindTune) begin
      changed = !tune_seen;
      for (int i = 0; i < 3; i++)
        if ({b[4*i+1], b[4*i]} != tune_angles[i] || {b[4*i+3], b[4*i+2]} != tune_times[i])
          changed = 1'b1;
    end else begin
      changed = !start_seen;
      for (int i = 0; i < 3; i++)
        if ({b[2*i+1], b[2*i]} != start_angles[i]) changed = 1'b1;
      if (frame.len == 4'd10)
        for (int i = 0; i < 4; i++)
          if (b[6+i] != bias_now[i]) changed = 1'b1;
    end
  end

  assign last_idx  = (cur.kind == KindTune) ? 2'd2 : (cur.kind == KindStart) ? 2'd3 : 2'd0;
  assign emit      = busy && (!res_valid || !res_stall);
  assign frame_pop = frame_ready && !busy;

  // Builds the beat for index idx of the latched frame.
  always_comb begin
    logic [7:0] cb [12];
    for (int i = 0; i < 12; i++) cb[i] = cur.data[i*8 +: 8];
    r = '0;
    r.frame_kind  = cur.kind;
    r.last_of_run = (idx == last_idx);
    case (cur.kind)
      KindBall: begin
        r.signed_word = {cb[1], cb[0]};
        r.small_a     = (cb[2] > ConfMax) ? ConfMax : cb[2];
        if (cur.len >= 4'd7) begin
          r.unsigned_word   = {cb[4], cb[3]};
          r.ball_frame_time = {cb[6], cb[5]};
          r.meta_flags      = 2'b01;
          if (cur.len == 4'd8) begin
            r.small_b    = cb[7];
            r.meta_flags = 2'b11;
          end
        end
      end
      KindCtrl: begin
        r.small_a     = cb[0];
        r.small_b     = cb[1];
        r.signed_word = {cb[3], cb[2]};
        r.small_c     = cb[4];
      end
      KindTune: begin
        r.slot           = idx;
        r.signed_word    = tune_angles[idx];
        r.unsigned_word  = tune_times[idx];
        r.revision_count = tune_revision;
      end
      KindStart: begin
        r.slot           = idx;
        r.signed_word    = (idx == 2'd3) ? 16'd0 : start_angles[idx];
        r.slot_bias      = bias_now[idx];
        r.revision_count = start_revision;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      idx            <= '0;
      res_valid      <= 1'b0;
      tune_seen      <= 1'b0;
      tune_revision  <= '0;
      start_seen     <= 1'b0;
      start_revision <= '0;
      bias_loaded    <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      if (emit) begin
        res_valid <= 1'b1;
        if (idx == last_idx) begin
          busy <= 1'b0;
          idx  <= '0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      if (frame_pop) begin
        busy <= 1'b1;
        idx  <= '0;
        if (frame.kind == KindTune) begin
          tune_seen <= 1'b1;
          if (changed) tune_revision <= tune_revision + 16'd1;
        end
        if (frame.kind == KindStart) begin
          start_seen <= 1'b1;
          if (changed) start_revision <= start_revision + 16'd1;
          if (frame.len == 4'd10) bias_loaded <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res <= r;
    if (frame_pop) begin
      cur <= frame;
      if (frame.kind == KindTune)
        for (int i = 0; i < 3; i++) begin
          tune_angles[i] <= {b[4*i+1], b[4*i]};
          tune_times[i]  <= {b[4*i+3], b[4*i+2]};
        end
      if (frame.kind == KindStart) begin
        for (int i = 0; i < 3; i++) start_angles[i] <= {b[2*i+1], b[2*i]};
        if (frame.len == 4'd10)
          for (int i = 0; i < 4; i++) bias_store[i] <= b[6+i];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) frame_pop |-> !busy)
    else $error("frame loaded during a run");
  assert property (@(posedge clk) disable iff (rst) (res_valid && res_stall) |=> $stable(res))
    else $error("stalled beat changed");
  assert property (@(posedge clk) disable iff (rst) busy |-> idx <= last_idx)
    else $error("run index past end");

endmodule
